### rtl/core/bsoc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and lookup helpers of the battery SOC estimator.
package bsoc_pkg;

	localparam int ACTION_W   = 2;
	localparam int VOLT_W     = 17;
	localparam int CUR_W      = 20;
	localparam int TIME_W     = 32;
	localparam int SOC_W      = 23;
	localparam int CAP_W      = 20;
	localparam int REST_W     = 17;
	localparam int ALPHA_W    = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [ACTION_W-1:0] ACT_SAMPLE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RESTORE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REST     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd2;

	localparam logic [CAP_W-1:0]   CAP_RESET   = 20'd20000;
	localparam logic [REST_W-1:0]  REST_RESET  = 17'd1000;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd62259;

	localparam logic [SOC_W-1:0]   SOC_FULL  = 23'd6553600;
	localparam logic [ALPHA_W-1:0] Q16_ONE   = 17'h10000;
	localparam logic [23:0]        DELTA_MAX = 24'd13107200;

	// Shared multiplier operand widths.
	localparam int MUL_A_W = 20;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Shared divider widths: numerator, divisor and quotient.
	localparam int DIV_NUM_W = 68;
	localparam int DIV_DEN_W = 36;
	localparam int DIV_Q_W   = 24;

	localparam int TABLE_POINTS = 13;
	localparam int SEG_W        = $clog2(TABLE_POINTS);
	localparam int PCT_W        = 7;

	localparam logic [VOLT_W-1:0] OCV_MV [TABLE_POINTS] = '{
		17'd42000, 17'd46000, 17'd48000, 17'd50000, 17'd52000, 17'd54000, 17'd56000,
		17'd58000, 17'd60000, 17'd62000, 17'd64000, 17'd66000, 17'd68000
	};
	localparam logic [PCT_W-1:0] OCV_PCT [TABLE_POINTS] = '{
		7'd0, 7'd5, 7'd10, 7'd20, 7'd35, 7'd50, 7'd65,
		7'd78, 7'd88, 7'd94, 7'd97, 7'd99, 7'd100
	};

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} div_status_t;

	// Picks the first segment whose upper breakpoint is not below the voltage.
	function automatic logic [SEG_W-1:0] seg_find(input logic [VOLT_W-1:0] v);
		logic [SEG_W-1:0] seg;
		seg = '0;
		for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
			if (v <= OCV_MV[i+1]) begin
				seg = SEG_W'(i);
			end
		end
		return seg;
	endfunction

	function automatic logic [VOLT_W-1:0] seg_lo_mv(input logic [SEG_W-1:0] seg);
		return OCV_MV[seg];
	endfunction

	function automatic logic [VOLT_W-1:0] seg_step_mv(input logic [SEG_W-1:0] seg);
		return OCV_MV[SEG_W'(seg + 1'b1)] - OCV_MV[seg];
	endfunction

	function automatic logic [SOC_W-1:0] seg_base_soc(input logic [SEG_W-1:0] seg);
		return {OCV_PCT[seg], 16'b0};
	endfunction

	function automatic logic [SOC_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
		return {OCV_PCT[SEG_W'(seg + 1'b1)] - OCV_PCT[seg], 16'b0};
	endfunction

endpackage

### rtl/core/bsoc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for estimator requests and SOC results.
interface bsoc_in_if;
	import bsoc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACTION_W-1:0]      action;
	logic [VOLT_W-1:0]        voltage_mv;
	logic signed [CUR_W-1:0]  current_ma;
	logic [TIME_W-1:0]        now_ms;
	logic [SOC_W-1:0]         restore_soc;

	modport source(output valid, action, voltage_mv, current_ma, now_ms, restore_soc,
		input ready);
	modport sink(input valid, action, voltage_mv, current_ma, now_ms, restore_soc,
		output ready);
endinterface

interface bsoc_out_if;
	import bsoc_pkg::*;

	logic             valid;
	logic             ready;
	logic [SOC_W-1:0] soc;
	logic             soc_valid;

	modport source(output valid, soc, soc_valid, input ready);
	modport sink(input valid, soc, soc_valid, output ready);
endinterface

### rtl/core/bsoc_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider shared by charge scaling and voltage interpolation.
module bsoc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bsoc_pkg::DIV_NUM_W-1:0]  num,
	input  logic [bsoc_pkg::DIV_DEN_W-1:0]  den,
	output logic [bsoc_pkg::DIV_Q_W-1:0]    quo,
	output bsoc_pkg::div_status_t           status
);
	import bsoc_pkg::*;

	localparam int TOP_W = DIV_NUM_W - DIV_Q_W;
	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   low_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;

	logic [TOP_W-1:0]     top;
	logic                 top_ovf;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;
	logic [DIV_DEN_W:0]   diff;

	assign top     = num[DIV_NUM_W-1:DIV_Q_W];
	assign top_ovf = top >= TOP_W'(den);
	assign trial   = {rem_q, low_q[DIV_Q_W-1]};
	assign fits    = trial >= {1'b0, den_q};
	assign diff    = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= top[DIV_DEN_W-1:0];
			low_q <= num[DIV_Q_W-1:0];
			den_q <= den;
			ovf_q <= top_ovf;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			low_q <= {low_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
		end
	end

	assign quo         = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;
	assign status.ovf  = ovf_q;
endmodule

### rtl/core/battery_soc_hybrid_estimator.sv
`timescale 1ns / 1ps
// Top level of the battery state-of-charge estimator with voltage correction.
// One transaction is worked on at a time and the request channel is ready only
// while the sequencer is idle. Restore, clear and the unused action code go
// straight from acceptance to the result. The first sample after reset or clear
// takes its SOC from the voltage curve alone, a charge-counting sample runs the
// charge division, and a sample at or below the rest current also applies the
// voltage blend. A voltage at or beyond either end of the curve skips the
// interpolation division. The sequencer uses the single 24-step radix-2 divider,
// once for the charge step and once for the voltage interpolation, and the single
// 20x32 multiplier that all products share one per cycle. Stalls on the result
// channel hold the sequencer in its done state. A finished result waits in the
// output register while the next transaction is accepted.
module battery_soc_hybrid_estimator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsoc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bsoc_pkg::CFG_DATA_W-1:0]  cfg_data,
	bsoc_in_if.sink                          request,
	bsoc_out_if.source                       result
);
	import bsoc_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_DEN  = 4'd1;
	localparam logic [ST_W-1:0] ST_PROD = 4'd2;
	localparam logic [ST_W-1:0] ST_DIVP = 4'd3;
	localparam logic [ST_W-1:0] ST_DIVW = 4'd4;
	localparam logic [ST_W-1:0] ST_OCV  = 4'd5;
	localparam logic [ST_W-1:0] ST_OCVS = 4'd6;
	localparam logic [ST_W-1:0] ST_OCVW = 4'd7;
	localparam logic [ST_W-1:0] ST_OCVD = 4'd8;
	localparam logic [ST_W-1:0] ST_BL1  = 4'd9;
	localparam logic [ST_W-1:0] ST_BL2  = 4'd10;
	localparam logic [ST_W-1:0] ST_BL3  = 4'd11;
	localparam logic [ST_W-1:0] ST_DONE = 4'd12;

	localparam int ACC_W = 41;

	logic [ST_W-1:0]       state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [REST_W-1:0]     rest_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic [SOC_W-1:0]      soc_q;
	logic                  anch_q;
	logic [TIME_W-1:0]     last_q;
	logic [VOLT_W-1:0]     volt_q;
	logic [CUR_W-1:0]      mag_q;
	logic                  neg_q;
	logic [TIME_W-1:0]     now_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [MUL_P_W-1:0]    mul_q;
	logic [SEG_W-1:0]      seg_q;
	logic [SOC_W-1:0]      ocv_q;
	logic [ACC_W-1:0]      acc_q;
	logic                  out_valid_q;
	logic [SOC_W-1:0]      out_soc_q;
	logic                  out_sv_q;

	logic                  accept;
	logic [CUR_W-1:0]      raw_cur;
	logic [CUR_W-1:0]      mag_c;
	logic [SOC_W-1:0]      rsoc_c;
	logic [CAP_W-1:0]      cap_eff;
	logic [ALPHA_W-1:0]    alpha_eff;
	logic [ALPHA_W-1:0]    alpha_inv;
	logic [TIME_W-1:0]     dt;
	logic [SEG_W-1:0]      seg_c;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [MUL_P_W-1:0]    mul_p;
	logic                  div_start;
	logic [DIV_NUM_W-1:0]  div_num;
	logic [DIV_DEN_W-1:0]  div_den;
	logic [DIV_Q_W-1:0]    div_quo;
	div_status_t           div_st;
	logic [DIV_Q_W-1:0]    delta;
	logic signed [25:0]    charged;
	logic [SOC_W-1:0]      charged_clamp;
	logic [ACC_W:0]        blend_sum;
	logic [25:0]           blend;
	logic [SOC_W-1:0]      blend_clamp;
	logic                  out_load;
	logic                  rest_hit;

	assign accept  = request.valid && request.ready;
	assign raw_cur = request.current_ma;
	assign mag_c   = raw_cur[CUR_W-1] ? (~raw_cur + 1'b1) : raw_cur;
	assign rsoc_c  = (request.restore_soc > SOC_FULL) ? SOC_FULL : request.restore_soc;

	assign cap_eff   = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign alpha_eff = alpha_q[ALPHA_W-1] ? Q16_ONE : alpha_q;
	assign alpha_inv = Q16_ONE - alpha_eff;
	assign dt        = now_q - last_q;
	assign seg_c     = seg_find(volt_q);
	assign rest_hit  = mag_q <= CUR_W'(rest_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DEN: begin
				mul_a = cap_eff;
				mul_b = 32'd36000;
			end
			ST_PROD: begin
				mul_a = mag_q;
				mul_b = dt;
			end
			ST_OCV: begin
				mul_a = MUL_A_W'(volt_q - seg_lo_mv(seg_c));
				mul_b = MUL_B_W'(seg_span(seg_c));
			end
			ST_BL1: begin
				mul_a = MUL_A_W'(alpha_eff);
				mul_b = MUL_B_W'(soc_q);
			end
			ST_BL2: begin
				mul_a = MUL_A_W'(alpha_inv);
				mul_b = MUL_B_W'(ocv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	always_comb begin
		div_start = 1'b0;
		div_num   = {mul_q, 16'b0} + DIV_NUM_W'(den_q >> 1);
		div_den   = den_q;
		unique case (state_q)
			ST_DIVP: begin
				div_start = 1'b1;
			end
			ST_OCVS: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'(mul_q[31:0]);
				div_den   = DIV_DEN_W'(seg_step_mv(seg_q));
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bsoc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.status (div_st)
	);

	assign delta   = (div_st.ovf || (div_quo > DELTA_MAX)) ? DELTA_MAX : div_quo;
	assign charged = neg_q ? ($signed({3'b0, soc_q}) - $signed({2'b0, delta}))
		: ($signed({3'b0, soc_q}) + $signed({2'b0, delta}));
	assign charged_clamp = (charged < 0) ? '0
		: ((charged > $signed({3'b0, SOC_FULL})) ? SOC_FULL : charged[SOC_W-1:0]);

	assign blend_sum   = {1'b0, acc_q} + (ACC_W+1)'(mul_q[ACC_W-1:0]) + (ACC_W+1)'(32768);
	assign blend       = blend_sum[ACC_W:16];
	assign blend_clamp = (blend > 26'(SOC_FULL)) ? SOC_FULL : blend[SOC_W-1:0];

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			rest_q  <= REST_RESET;
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CAPACITY: cap_q   <= cfg_data[CAP_W-1:0];
				CFG_REST:     rest_q  <= cfg_data[REST_W-1:0];
				CFG_ALPHA:    alpha_q <= cfg_data[ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			soc_q   <= '0;
			anch_q  <= 1'b0;
			last_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (request.action == ACT_SAMPLE) begin
							state_q <= anch_q ? ST_DEN : ST_OCV;
						end else if (request.action == ACT_RESTORE) begin
							soc_q   <= rsoc_c;
							anch_q  <= 1'b1;
							last_q  <= request.now_ms;
							state_q <= ST_DONE;
						end else if (request.action == ACT_CLEAR) begin
							soc_q   <= '0;
							anch_q  <= 1'b0;
							last_q  <= request.now_ms;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DEN:  state_q <= ST_PROD;
				ST_PROD: state_q <= ST_DIVP;
				ST_DIVP: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_st.done) begin
						soc_q   <= charged_clamp;
						last_q  <= now_q;
						state_q <= rest_hit ? ST_OCV : ST_DONE;
					end
				end
				ST_OCV: begin
					if (volt_q <= OCV_MV[0] || volt_q >= OCV_MV[TABLE_POINTS-1]) begin
						state_q <= ST_OCVD;
					end else begin
						state_q <= ST_OCVS;
					end
				end
				ST_OCVS: state_q <= ST_OCVW;
				ST_OCVW: begin
					if (div_st.done) begin
						state_q <= ST_OCVD;
					end
				end
				ST_OCVD: begin
					if (!anch_q) begin
						soc_q   <= ocv_q;
						anch_q  <= 1'b1;
						last_q  <= now_q;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_BL1;
					end
				end
				ST_BL1: state_q <= ST_BL2;
				ST_BL2: state_q <= ST_BL3;
				ST_BL3: begin
					soc_q   <= blend_clamp;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			volt_q <= request.voltage_mv;
			mag_q  <= mag_c;
			neg_q  <= raw_cur[CUR_W-1];
			now_q  <= request.now_ms;
		end
		mul_q <= mul_p;
		if (state_q == ST_PROD) begin
			den_q <= mul_q[DIV_DEN_W-1:0];
		end
		if (state_q == ST_OCV) begin
			seg_q <= seg_c;
			if (volt_q <= OCV_MV[0]) begin
				ocv_q <= '0;
			end else if (volt_q >= OCV_MV[TABLE_POINTS-1]) begin
				ocv_q <= SOC_FULL;
			end
		end
		if (state_q == ST_OCVW && div_st.done) begin
			ocv_q <= seg_base_soc(seg_q) + div_quo[SOC_W-1:0];
		end
		if (state_q == ST_BL2) begin
			acc_q <= mul_q[ACC_W-1:0];
		end
		if (out_load) begin
			out_soc_q <= anch_q ? soc_q : '0;
			out_sv_q  <= anch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign request.ready    = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.soc       = out_soc_q;
	assign result.soc_valid = out_sv_q;
endmodule
